// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define CHK_SAME(lbl, ante, cons)

`define CHK_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/pib_pkg.sv =====
// ----------------------------------------------------------------------------
// pib_pkg
// Shared types and constants for the palette icon blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pib_pkg;

  localparam int PALETTE_ENTRIES_DEF = 255;
  localparam int ICON_DIM_MAX        = 1023;
  localparam int MAP_WORD_W          = 16;
  localparam int BUF_W               = 24;
  localparam int MAX_INDEX_BITS      = 8;

  typedef enum logic [1:0] {
    OP_PAL_WRITE = 2'd0,
    OP_START     = 2'd1,
    OP_MAP_WORD  = 2'd2
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/palette_icon_blitter.sv =====
// ----------------------------------------------------------------------------
// palette_icon_blitter
// Decodes a palette-indexed icon stream into scaled, colored screen blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry one of three ops: palette write,
//   start icon or map word. Palette writes and starts are complete once
//   the beat is accepted. A map word appends 16 bits to the bit buffer;
//   while the receiver accepts, the step loop then takes one index per
//   cycle, and every nonzero index reads the palette RAM and yields one
//   block beat on out_valid/out_ready, out_last marking the final block of
//   that word. Each index of a word passes through the step loop, the
//   single palette read port, the RAM read and the last-flag lookahead
//   stages; in_ready stays low meanwhile, so one word is in work at a time.
//   The output register parts the two sides: a new item may be accepted
//   while the final block still waits. When the receiver stalls, the step
//   loop, the RAM read stage and the lookahead stage all freeze.
//   Reset clears the geometry, the bit buffer and the palette valid bits, so
//   palette entries read as black until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module palette_icon_blitter
  import pib_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_start_x,
  input  wire logic [15:0] in_start_y,
  input  wire logic        in_anchor_right,
  input  wire logic        in_anchor_bottom,
  input  wire logic [9:0]  in_icon_width,
  input  wire logic [9:0]  in_icon_height,
  input  wire logic [3:0]  in_bits_per_index,
  input  wire logic [7:0]  in_pixel_scale,
  input  wire logic [15:0] in_map_word,
  input  wire logic [7:0]  in_palette_slot,
  input  wire logic [23:0] in_palette_color,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_pixel_x,
  output logic [15:0]      out_pixel_y,
  output logic [7:0]       out_block_size,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last
);

  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // palette RAM and per-entry valid bits
  logic [23:0]          pal_mem [PALETTE_ENTRIES];
  logic [23:0]          pal_q_r;
  logic [PALETTE_ENTRIES-1:0] pal_vld_r, pal_vld_nxt;

  // geometry and stream state
  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [9:0]       col_r, col_nxt;
  logic [9:0]       row_r, row_nxt;
  logic [9:0]       wid_r, wid_nxt;
  logic [9:0]       hgt_r, hgt_nxt;
  logic [3:0]       bits_r, bits_nxt;
  logic [7:0]       scale_r, scale_nxt;
  logic [15:0]      org_x_r, org_x_nxt;
  logic [15:0]      cur_x_r, cur_x_nxt;
  logic [15:0]      cur_y_r, cur_y_nxt;
  logic             active_r, active_nxt;

  // RAM read stage
  logic             rd_v_r, rd_v_nxt;
  logic [15:0]      m_x_r, m_x_nxt;
  logic [15:0]      m_y_r, m_y_nxt;
  logic             m_zero_r, m_zero_nxt;

  // lookahead stage: holds a block until we know whether it is the last one
  logic             hold_v_r, hold_v_nxt;
  logic [15:0]      h_x_r, h_x_nxt;
  logic [15:0]      h_y_r, h_y_nxt;
  logic [23:0]      h_col_r, h_col_nxt;

  // output register
  logic             out_v_r, out_v_nxt;
  logic [15:0]      o_x_r, o_x_nxt;
  logic [15:0]      o_y_r, o_y_nxt;
  logic [7:0]       o_size_r, o_size_nxt;
  logic [23:0]      o_col_r, o_col_nxt;
  logic             o_last_r, o_last_nxt;

  // step logic
  logic             in_fire;
  logic             step_go;
  logic             adv;
  logic [7:0]       idx_mask;
  logic [7:0]       idx;
  logic [7:0]       idx_m1;
  logic             idx_oor;
  logic [PAL_AW-1:0] rd_addr;
  logic             rd_en;
  logic             pal_we;
  logic [PAL_AW-1:0] wr_addr;
  logic [10:0]      col_inc;
  logic [10:0]      row_inc;
  logic [23:0]      rd_color;

  // start decode
  logic [3:0]       st_bits;
  logic [7:0]       st_scale;
  logic [9:0]       st_wid;
  logic [9:0]       st_hgt;
  logic [17:0]      st_span_x;
  logic [17:0]      st_span_y;
  logic [15:0]      st_org_x;
  logic [15:0]      st_org_y;

  assign step_go  = active_r && (cnt_r >= {1'b0, bits_r});
  assign in_ready = !(step_go || rd_v_r || hold_v_r);
  assign in_fire  = in_valid && in_ready;
  assign adv      = !out_v_r || out_ready;

  assign idx_mask = 8'((9'd1 << bits_r) - 9'd1);
  assign idx      = buf_r[7:0] & idx_mask;
  assign idx_m1   = idx - 8'd1;
  assign idx_oor  = idx_m1 >= 8'(PALETTE_ENTRIES);
  assign rd_addr  = idx_m1[PAL_AW-1:0];
  assign rd_en    = adv && step_go && (idx != 8'd0);
  assign col_inc  = {1'b0, col_r} + 11'd1;
  assign row_inc  = {1'b0, row_r} + 11'd1;
  assign rd_color = m_zero_r ? 24'd0 : pal_q_r;

  assign pal_we  = in_fire && (in_op == OP_PAL_WRITE) &&
                   (in_palette_slot < 8'(PALETTE_ENTRIES));
  assign wr_addr = in_palette_slot[PAL_AW-1:0];

  always_comb begin
    if (in_bits_per_index == 4'd0) begin
      st_bits = 4'd1;
    end else if (in_bits_per_index > 4'(MAX_INDEX_BITS)) begin
      st_bits = 4'(MAX_INDEX_BITS);
    end else begin
      st_bits = in_bits_per_index;
    end
    st_scale  = (in_pixel_scale == 8'd0) ? 8'd1 : in_pixel_scale;
    st_wid    = (int'(in_icon_width) > ICON_DIM_MAX) ? 10'(ICON_DIM_MAX) : in_icon_width;
    st_hgt    = (int'(in_icon_height) > ICON_DIM_MAX) ? 10'(ICON_DIM_MAX) : in_icon_height;
    st_span_x = 18'(st_wid) * 18'(st_scale);
    st_span_y = 18'(st_hgt) * 18'(st_scale);
    st_org_x  = in_anchor_right  ? (in_start_x - st_span_x[15:0]) : in_start_x;
    st_org_y  = in_anchor_bottom ? (in_start_y - st_span_y[15:0]) : in_start_y;
  end

  always_comb begin
    pal_vld_nxt = pal_vld_r;
    buf_nxt     = buf_r;
    cnt_nxt     = cnt_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    wid_nxt     = wid_r;
    hgt_nxt     = hgt_r;
    bits_nxt    = bits_r;
    scale_nxt   = scale_r;
    org_x_nxt   = org_x_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    active_nxt  = active_r;
    rd_v_nxt    = rd_v_r;
    m_x_nxt     = m_x_r;
    m_y_nxt     = m_y_r;
    m_zero_nxt  = m_zero_r;
    hold_v_nxt  = hold_v_r;
    h_x_nxt     = h_x_r;
    h_y_nxt     = h_y_r;
    h_col_nxt   = h_col_r;
    out_v_nxt   = out_v_r && !out_ready;
    o_x_nxt     = o_x_r;
    o_y_nxt     = o_y_r;
    o_size_nxt  = o_size_r;
    o_col_nxt   = o_col_r;
    o_last_nxt  = o_last_r;

    if (in_fire) begin
      case (in_op)
        OP_PAL_WRITE: begin
          if (pal_we) begin
            pal_vld_nxt[wr_addr] = 1'b1;
          end
        end
        OP_START: begin
          bits_nxt   = st_bits;
          scale_nxt  = st_scale;
          wid_nxt    = st_wid;
          hgt_nxt    = st_hgt;
          org_x_nxt  = st_org_x;
          cur_x_nxt  = st_org_x;
          cur_y_nxt  = st_org_y;
          buf_nxt    = '0;
          cnt_nxt    = '0;
          col_nxt    = '0;
          row_nxt    = '0;
          active_nxt = (st_wid != 10'd0) && (st_hgt != 10'd0);
        end
        OP_MAP_WORD: begin
          // held bits stay below 8 between words
          if (active_r) begin
            buf_nxt = buf_r | (BUF_W'(in_map_word) << cnt_r[2:0]);
            cnt_nxt = cnt_r + 5'(MAP_WORD_W);
          end
        end
        default: begin
        end
      endcase
    end

    if (adv) begin
      // lookahead and output stages
      if (rd_v_r) begin
        if (hold_v_r) begin
          out_v_nxt  = 1'b1;
          o_x_nxt    = h_x_r;
          o_y_nxt    = h_y_r;
          o_size_nxt = scale_r;
          o_col_nxt  = h_col_r;
          o_last_nxt = 1'b0;
        end
        hold_v_nxt = 1'b1;
        h_x_nxt    = m_x_r;
        h_y_nxt    = m_y_r;
        h_col_nxt  = rd_color;
      end else if (!step_go && hold_v_r) begin
        out_v_nxt  = 1'b1;
        o_x_nxt    = h_x_r;
        o_y_nxt    = h_y_r;
        o_size_nxt = scale_r;
        o_col_nxt  = h_col_r;
        o_last_nxt = 1'b1;
        hold_v_nxt = 1'b0;
      end

      // step loop: one index per cycle while the output can advance
      rd_v_nxt = rd_en;
      if (step_go) begin
        m_x_nxt    = cur_x_r;
        m_y_nxt    = cur_y_r;
        m_zero_nxt = idx_oor || !pal_vld_r[rd_addr];
        buf_nxt    = buf_r >> bits_r;
        cnt_nxt    = cnt_r - {1'b0, bits_r};
        if (col_inc >= {1'b0, wid_r}) begin
          col_nxt   = '0;
          cur_x_nxt = org_x_r;
          row_nxt   = row_inc[9:0];
          cur_y_nxt = cur_y_r + 16'(scale_r);
          if (row_inc >= {1'b0, hgt_r}) begin
            active_nxt = 1'b0;
            buf_nxt    = '0;
            cnt_nxt    = '0;
          end
        end else begin
          col_nxt   = col_inc[9:0];
          cur_x_nxt = cur_x_r + 16'(scale_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[wr_addr] <= in_palette_color;
    end
    if (rd_en) begin
      pal_q_r <= pal_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
      buf_r     <= '0;
      cnt_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
      wid_r     <= '0;
      hgt_r     <= '0;
      bits_r    <= 4'd1;
      scale_r   <= 8'd1;
      org_x_r   <= '0;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      active_r  <= 1'b0;
      rd_v_r    <= 1'b0;
      hold_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      pal_vld_r <= pal_vld_nxt;
      buf_r     <= buf_nxt;
      cnt_r     <= cnt_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      wid_r     <= wid_nxt;
      hgt_r     <= hgt_nxt;
      bits_r    <= bits_nxt;
      scale_r   <= scale_nxt;
      org_x_r   <= org_x_nxt;
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      active_r  <= active_nxt;
      rd_v_r    <= rd_v_nxt;
      hold_v_r  <= hold_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_x_r    <= m_x_nxt;
    m_y_r    <= m_y_nxt;
    m_zero_r <= m_zero_nxt;
    h_x_r    <= h_x_nxt;
    h_y_r    <= h_y_nxt;
    h_col_r  <= h_col_nxt;
    o_x_r    <= o_x_nxt;
    o_y_r    <= o_y_nxt;
    o_size_r <= o_size_nxt;
    o_col_r  <= o_col_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_pixel_x    = o_x_r;
  assign out_pixel_y    = o_y_r;
  assign out_block_size = o_size_r;
  assign out_red        = o_col_r[23:16];
  assign out_green      = o_col_r[15:8];
  assign out_blue       = o_col_r[7:0];
  assign out_last       = o_last_r;

  // a map word taken while drawing always starts the step loop
  `CHK_NEXT(a_map_busy, in_fire && (in_op == OP_MAP_WORD) && active_r, !in_ready)
  // between beats the buffer never holds a whole index
  `CHK_SAME(a_idle_drained, in_ready && active_r, (cnt_r < {1'b0, bits_r}))
  // draining the lookahead stage produces the word's final block
  `CHK_NEXT(a_last_flush, adv && !step_go && !rd_v_r && hold_v_r, out_v_r && o_last_r)

endmodule

`default_nettype wire

// ===== sim/tb_palette_icon_blitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_icon_blitter
// Self-checking bench for the palette icon blitter. Feeds palette writes,
// icon starts and map words over the input channel. A scoreboard tracks the
// palette, the geometry and the bit buffer, and queues the blocks each beat
// should produce. It then compares every output beat against that queue.
// ----------------------------------------------------------------------------
module tb_palette_icon_blitter;
  import pib_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] sx;
    logic [15:0] sy;
    logic        anc_r;
    logic        anc_b;
    logic [9:0]  w;
    logic [9:0]  h;
    logic [3:0]  bpi;
    logic [7:0]  scale;
    logic [15:0] word;
    logic [7:0]  slot;
    logic [23:0] color;
  } in_beat_t;

  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  size;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } block_t;

  class block_scoreboard;
    logic [23:0] palette [PALETTE_ENTRIES_DEF];
    logic [23:0] bit_acc;
    int unsigned acc_bits, col, row, icon_w, icon_h, idx_bits, scale;
    logic [15:0] org_x, org_y;
    bit          drawing;
    block_t      expected_blocks[$];
    int          errors, blocks_checked, icons_started;

    function new();
      foreach (palette[i]) palette[i] = '0;
      bit_acc  = '0;
      org_x    = '0;
      org_y    = '0;
      idx_bits = 1;
      scale    = 1;
    endfunction

    // Returns 1 when the beat changed state or produced blocks.
    function bit apply_beat(in_beat_t b);
      int unsigned n, idx;
      logic [23:0] color;
      block_t blk;
      n = 0;
      case (b.op)
        OP_PAL_WRITE: begin
          if (b.slot >= PALETTE_ENTRIES_DEF) return 1'b0;
          palette[b.slot] = b.color;
          return 1'b1;
        end
        OP_START: begin
          idx_bits = (b.bpi == 0) ? 1 : (b.bpi > MAX_INDEX_BITS) ? MAX_INDEX_BITS : b.bpi;
          scale    = (b.scale == 0) ? 1 : b.scale;
          icon_w   = (b.w > ICON_DIM_MAX) ? ICON_DIM_MAX : b.w;
          icon_h   = (b.h > ICON_DIM_MAX) ? ICON_DIM_MAX : b.h;
          org_x    = b.anc_r ? 16'(b.sx - icon_w * scale) : b.sx;
          org_y    = b.anc_b ? 16'(b.sy - icon_h * scale) : b.sy;
          bit_acc  = '0;
          acc_bits = 0;
          col      = 0;
          row      = 0;
          drawing  = (icon_w != 0) && (icon_h != 0);
          if (drawing) icons_started++;
          return 1'b1;
        end
        OP_MAP_WORD: begin
          if (!drawing) return 1'b0;
          // fewer than idx_bits bits are held, so the new word fits in 24 bits
          bit_acc  = bit_acc | (24'(b.word) << (acc_bits & 7));
          acc_bits += MAP_WORD_W;
          while (drawing && acc_bits >= idx_bits) begin
            idx = bit_acc & ((1 << idx_bits) - 1);
            if (idx != 0 && n < 16) begin
              color     = (idx - 1 < PALETTE_ENTRIES_DEF) ? palette[idx - 1] : '0;
              blk.px    = 16'(org_x + col * scale);
              blk.py    = 16'(org_y + row * scale);
              blk.size  = 8'(scale);
              blk.red   = color[23:16];
              blk.green = color[15:8];
              blk.blue  = color[7:0];
              blk.last  = 1'b0;
              expected_blocks.push_back(blk);
              n++;
            end
            bit_acc  = bit_acc >> idx_bits;
            acc_bits -= idx_bits;
            col++;
            if (col >= icon_w) begin
              col = 0;
              row++;
              if (row >= icon_h) begin
                drawing  = 1'b0;
                bit_acc  = '0;
                acc_bits = 0;
              end
            end
          end
          if (n > 0) expected_blocks[expected_blocks.size() - 1].last = 1'b1;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    function void check_block(block_t got);
      block_t want;
      if (expected_blocks.size() == 0) begin
        errors++;
        $error("unexpected block beat at x=0x%0h y=0x%0h", got.px, got.py);
        return;
      end
      want = expected_blocks.pop_front();
      blocks_checked++;
      cmp("pixel_x", want.px, got.px);
      cmp("pixel_y", want.py, got.py);
      cmp("block_size", want.size, got.size);
      cmp("red", want.red, got.red);
      cmp("green", want.green, got.green);
      cmp("blue", want.blue, got.blue);
      cmp("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [15:0] in_start_x = '0;
  logic [15:0] in_start_y = '0;
  logic        in_anchor_right = 1'b0;
  logic        in_anchor_bottom = 1'b0;
  logic [9:0]  in_icon_width = '0;
  logic [9:0]  in_icon_height = '0;
  logic [3:0]  in_bits_per_index = '0;
  logic [7:0]  in_pixel_scale = '0;
  logic [15:0] in_map_word = '0;
  logic [7:0]  in_palette_slot = '0;
  logic [23:0] in_palette_color = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pixel_x;
  logic [15:0] out_pixel_y;
  logic [7:0]  out_block_size;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_last;

  block_scoreboard sb;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  logic hold_rx = 1'b0;

  palette_icon_blitter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_anchor_right   (in_anchor_right),
    .in_anchor_bottom  (in_anchor_bottom),
    .in_icon_width     (in_icon_width),
    .in_icon_height    (in_icon_height),
    .in_bits_per_index (in_bits_per_index),
    .in_pixel_scale    (in_pixel_scale),
    .in_map_word       (in_map_word),
    .in_palette_slot   (in_palette_slot),
    .in_palette_color  (in_palette_color),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_block_size    (out_block_size),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    b.op    = 2'($urandom_range(3));
    b.sx    = 16'($urandom);
    b.sy    = 16'($urandom);
    b.anc_r = 1'($urandom);
    b.anc_b = 1'($urandom);
    b.w     = 10'($urandom);
    b.h     = 10'($urandom);
    b.bpi   = 4'($urandom);
    b.scale = 8'($urandom);
    b.word  = 16'($urandom);
    b.slot  = 8'($urandom);
    b.color = 24'($urandom);
    return b;
  endfunction

  // Holds valid and payload until the beat is taken; valid stays up into the
  // next beat unless the sender decides to idle.
  task automatic offer(in_beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= b.op;
    in_start_x        <= b.sx;
    in_start_y        <= b.sy;
    in_anchor_right   <= b.anc_r;
    in_anchor_bottom  <= b.anc_b;
    in_icon_width     <= b.w;
    in_icon_height    <= b.h;
    in_bits_per_index <= b.bpi;
    in_pixel_scale    <= b.scale;
    in_map_word       <= b.word;
    in_palette_slot   <= b.slot;
    in_palette_color  <= b.color;
    do @(posedge clk); while (!in_ready);
    if (sb.apply_beat(b)) items_sent++;
  endtask

  task automatic pal_write(logic [7:0] slot, logic [23:0] color);
    in_beat_t b;
    b       = rand_beat();
    b.op    = OP_PAL_WRITE;
    b.slot  = slot;
    b.color = color;
    offer(b);
  endtask

  task automatic start_icon(logic [15:0] x, logic [15:0] y, logic ar, logic ab,
                            logic [9:0] w, logic [9:0] h, logic [3:0] bpi,
                            logic [7:0] sc);
    in_beat_t b;
    b       = rand_beat();
    b.op    = OP_START;
    b.sx    = x;
    b.sy    = y;
    b.anc_r = ar;
    b.anc_b = ab;
    b.w     = w;
    b.h     = h;
    b.bpi   = bpi;
    b.scale = sc;
    offer(b);
  endtask

  task automatic map_word(logic [15:0] word);
    in_beat_t b;
    b      = rand_beat();
    b.op   = OP_MAP_WORD;
    b.word = word;
    offer(b);
  endtask

  always @(posedge clk) begin
    out_ready <= hold_rx ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : out_monitor
    block_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pixel_x, out_pixel_y, out_block_size, out_red, out_green, out_blue,
              out_last};
      sb.check_block(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Long output stall while blocks are pending, so the block backs up and
  // drops in_ready while the sender keeps offering.
  initial begin
    do @(posedge clk); while (!(items_sent >= 120 && sb.pending() > 0));
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    int unsigned w, h, bpi, eff, words;
    int targets [3];
    targets = '{100, 190, 280};
    sb = new();
    tx_idle_pct = 29;
    rx_idle_pct = 45;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle/ignored beats, palette corners, anchors, index widths
    map_word(16'hFFFF);
    begin
      in_beat_t nb;
      nb    = rand_beat();
      nb.op = OP_RESERVED;
      offer(nb);
    end
    pal_write(8'd0, 24'hFFFFFF);
    pal_write(8'd254, 24'h123456);
    pal_write(8'd255, 24'hABCDEF);
    pal_write(8'd1, 24'h000000);
    pal_write(8'd2, 24'h5A5AA5);
    // zero scale, both anchors, origin wraps below zero
    start_icon(16'h0000, 16'h0000, 1'b1, 1'b1, 10'd4, 10'd4, 4'd1, 8'd0);
    map_word(16'hFFFF);
    // oversized index width clamps to 8, max scale, widest icon
    start_icon(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 10'd1023, 10'd1, 4'd15, 8'd255);
    map_word(16'hFF01);
    map_word(16'h0000);
    // empty icon then a word that must be dropped
    start_icon(16'h1234, 16'h4321, 1'b1, 1'b0, 10'd0, 10'd5, 4'd4, 8'd3);
    map_word(16'hFFFF);
    // bits spill across words and rows; leftover bits dropped at icon end
    start_icon(16'd100, 16'd200, 1'b0, 1'b1, 10'd3, 10'd2, 4'd3, 8'd2);
    map_word(16'hB6DB);
    map_word(16'hFFFF);
    // zero index width runs as one bit per index
    start_icon(16'h8000, 16'h0010, 1'b0, 1'b0, 10'd5, 10'd1, 4'd0, 8'd8);
    map_word(16'hAAAA);
    // restart mid-icon discards held bits
    start_icon(16'h0040, 16'h0040, 1'b1, 1'b1, 10'd7, 10'd3, 4'd5, 8'd17);
    map_word(16'h7FFF);
    start_icon(16'h0300, 16'h0200, 1'b0, 1'b0, 10'd2, 10'd2, 4'd2, 8'd255);
    map_word(16'hE4E4);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 29; rx_idle_pct = 45; end
        1: begin tx_idle_pct = 45; rx_idle_pct = 29; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      while (items_sent < targets[ph]) begin
        if ($urandom_range(7) == 0) begin
          offer(rand_beat());
        end else begin
          repeat ($urandom_range(3))
            pal_write(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(15)),
                      24'($urandom));
          if ($urandom_range(14) == 0) begin
            // one long strip in either direction
            bpi = 1;
            if ($urandom_range(1)) begin
              w = $urandom_range(1023);
              h = 1;
            end else begin
              w = 1;
              h = $urandom_range(1023);
            end
          end else begin
            bpi = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
            w   = $urandom_range(6);
            h   = $urandom_range(1, 5);
          end
          eff = (bpi == 0) ? 1 : (bpi > MAX_INDEX_BITS) ? MAX_INDEX_BITS : bpi;
          start_icon(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                     10'(w), 10'(h), 4'(bpi), 8'($urandom));
          words = (w * h * eff + MAP_WORD_W - 1) / MAP_WORD_W;
          if ($urandom_range(4) == 0) words = $urandom_range(words);
          repeat (words) map_word(16'($urandom));
          if ($urandom_range(7) == 0) map_word(16'($urandom));
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d effective input beats, %0d icons drawn, %0d blocks checked,",
             items_sent, sb.icons_started, sb.blocks_checked);
    $display("under three idling mixes on both channels plus one long output stall.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
